// File: src/pidwi_pkg.sv
// ----------------------------------------------------------------------------
// pidwi_pkg
// Types, register codes and reset values shared by the windowed-integral PID.
// ----------------------------------------------------------------------------
package pidwi_pkg;

    // Default integrator width (signed, saturating)
    localparam int INTEGRAL_WIDTH_DEF = 40;

    // The integral is clamped to +-2^TERM_CLAMP_SHIFT before the gain multiply.
    // Beyond that magnitude the integral term outweighs the P and D terms by
    // far more than any drive limit, so the clamped drive is unchanged.
    localparam int TERM_CLAMP_SHIFT = 50;
    localparam int ICLAMP_WIDTH     = TERM_CLAMP_SHIFT + 2;

    // Command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_GAIN_P          = 3'd0,
        CFG_GAIN_I          = 3'd1,
        CFG_GAIN_D          = 3'd2,
        CFG_INTEGRAL_WINDOW = 3'd3,
        CFG_SETTLE_ERROR    = 3'd4,
        CFG_SETTLE_RATE     = 3'd5,
        CFG_TIMEOUT_SAMPLES = 3'd6,
        CFG_OUTPUT_LIMIT    = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [15:0] RST_GAIN_P          = 16'd441;
    localparam logic [15:0] RST_GAIN_I          = 16'd8;
    localparam logic [15:0] RST_GAIN_D          = 16'd2702;
    localparam logic [30:0] RST_INTEGRAL_WINDOW = 31'd3840;
    localparam logic [30:0] RST_SETTLE_ERROR    = 31'd640;
    localparam logic [30:0] RST_SETTLE_RATE     = 31'd77;
    localparam logic [15:0] RST_TIMEOUT_SAMPLES = 16'd133;
    localparam logic [6:0]  RST_OUTPUT_LIMIT    = 7'd127;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [30:0] integral_window;
        logic [30:0] settle_error;
        logic [30:0] settle_rate;
        logic [15:0] timeout_samples;
        logic [6:0]  output_limit;
    } t_cfg;

    // Move state apart from the integrator, whose width is a parameter
    typedef struct packed {
        logic signed [31:0] target;
        logic signed [31:0] initial_reading;
        logic signed [31:0] prev_error;
        logic [15:0]        sample_count;
        logic               active;
    } t_move_state;

    typedef struct packed {
        logic signed [7:0]  drive;
        logic               done_res;
        logic               timed_out;
        logic signed [31:0] error_value;
    } t_result;

endpackage

// File: src/pidwi_core.sv
// ----------------------------------------------------------------------------
// pidwi_core
// Single-pass PID datapath: error, windowed integral, derivative, drive clamp
// and settle/timeout decision for one registered transaction.
// ----------------------------------------------------------------------------
module pidwi_core
    import pidwi_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
    input  t_cfg                              i_cfg,
    input  t_move_state                       i_state,
    input  logic signed [INTEGRAL_WIDTH-1:0]  i_integral,
    input  logic                              i_command,
    input  logic signed [31:0]                i_target,
    input  logic signed [31:0]                i_reading,
    output t_move_state                       o_state,
    output logic signed [INTEGRAL_WIDTH-1:0]  o_integral,
    output t_result                           o_result
);

    localparam int IW1 = INTEGRAL_WIDTH + 1;
    localparam logic signed [INTEGRAL_WIDTH-1:0] IMAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    localparam logic signed [INTEGRAL_WIDTH-1:0] IMIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
    localparam logic signed [63:0] ICAP_POS = 64'sd1 <<< TERM_CLAMP_SHIFT;
    localparam logic signed [63:0] ICAP_NEG = -ICAP_POS;

    logic signed [33:0]               err_wide;
    logic signed [31:0]               err;
    logic [31:0]                      err_mag;
    logic signed [32:0]               deriv;
    logic [32:0]                      deriv_mag;
    logic signed [INTEGRAL_WIDTH:0]   isum;
    logic signed [INTEGRAL_WIDTH-1:0] integ_nxt;
    logic signed [63:0]               integ_ext;
    logic signed [ICLAMP_WIDTH-1:0]   integ_clamp;
    logic signed [16:0]               gp, gi, gd;
    logic signed [48:0]               p_term;
    logic signed [49:0]               d_term;
    logic signed [68:0]               i_term;
    logic signed [69:0]               pid_sum;
    logic [69:0]                      sum_mag;
    logic [53:0]                      q_full;
    logic [6:0]                       q_clamp;
    logic signed [7:0]                drive;
    logic [15:0]                      count_nxt;
    logic                             settled;
    logic                             tmo;

    // error = target - (reading - initial), saturated to 32 bits
    always_comb begin
        err_wide = 34'(i_state.target) - (34'(i_reading) - 34'(i_state.initial_reading));
        if (err_wide[33:31] == 3'b000 || err_wide[33:31] == 3'b111) begin
            err = err_wide[31:0];
        end else if (err_wide[33]) begin
            err = {1'b1, 31'd0};
        end else begin
            err = {1'b0, {31{1'b1}}};
        end
        err_mag   = err[31] ? (~err + 32'd1) : err;
        deriv     = 33'(err) - 33'(i_state.prev_error);
        deriv_mag = deriv[32] ? (~deriv + 33'd1) : deriv;
    end

    // Windowed, saturating integral
    always_comb begin
        isum = IW1'(i_integral) + IW1'(err);
        if (err_mag < {1'b0, i_cfg.integral_window}) begin
            if (isum[INTEGRAL_WIDTH] != isum[INTEGRAL_WIDTH-1]) begin
                integ_nxt = isum[INTEGRAL_WIDTH] ? IMIN : IMAX;
            end else begin
                integ_nxt = isum[INTEGRAL_WIDTH-1:0];
            end
        end else begin
            integ_nxt = i_integral;
        end
        integ_ext = 64'(integ_nxt);
        if (integ_ext > ICAP_POS) begin
            integ_clamp = ICLAMP_WIDTH'(ICAP_POS);
        end else if (integ_ext < ICAP_NEG) begin
            integ_clamp = ICLAMP_WIDTH'(ICAP_NEG);
        end else begin
            integ_clamp = ICLAMP_WIDTH'(integ_ext);
        end
    end

    // Three products and the sum, truncated toward zero, clamped
    always_comb begin
        gp      = signed'({1'b0, i_cfg.gain_p});
        gi      = signed'({1'b0, i_cfg.gain_i});
        gd      = signed'({1'b0, i_cfg.gain_d});
        p_term  = err * gp;
        d_term  = deriv * gd;
        i_term  = integ_clamp * gi;
        pid_sum = 70'(p_term) + 70'(i_term) + 70'(d_term);
        sum_mag = pid_sum[69] ? (~pid_sum + 70'd1) : pid_sum;
        q_full  = sum_mag[69:16];
        q_clamp = (q_full > 54'(i_cfg.output_limit)) ? i_cfg.output_limit : q_full[6:0];
        drive   = pid_sum[69] ? -signed'({1'b0, q_clamp}) : signed'({1'b0, q_clamp});
    end

    always_comb begin
        count_nxt = (i_state.sample_count == COUNT_MAX) ? i_state.sample_count
                                                        : i_state.sample_count + 16'd1;
        settled   = (err_mag < {1'b0, i_cfg.settle_error}) &&
                    (deriv_mag < {2'b00, i_cfg.settle_rate});
        tmo       = !settled && (count_nxt > i_cfg.timeout_samples);
    end

    always_comb begin
        o_state    = i_state;
        o_integral = i_integral;
        o_result   = '0;
        if (i_command == CMD_START) begin
            o_state.target          = i_target;
            o_state.initial_reading = i_reading;
            o_state.prev_error      = '0;
            o_state.sample_count    = '0;
            o_state.active          = 1'b1;
            o_integral              = '0;
            o_result.error_value    = i_target;
        end else if (!i_state.active) begin
            o_result.done_res = 1'b1;
        end else begin
            o_state.prev_error   = err;
            o_state.sample_count = count_nxt;
            o_integral           = integ_nxt;
            o_result.error_value = err;
            if (settled || tmo) begin
                o_state.active     = 1'b0;
                o_result.done_res  = 1'b1;
                o_result.timed_out = tmo;
            end else begin
                o_result.drive = drive;
            end
        end
    end

endmodule

// File: src/pid_with_windowed_integral_top.sv
// ----------------------------------------------------------------------------
// pid_with_windowed_integral_top
// PID move controller with conditional integration, Q24.8 data, Q8.8 gains.
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------------
//  input   | i_in_valid / o_in_stall   | i_command, i_target, i_reading
//  result  | o_out_valid / i_out_stall | o_drive, o_done_res, o_timed_out, o_error_value
//  config  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One result transaction per input transaction, through the input register,
//  then the single-pass PID datapath into the result register.
//  A new transaction is taken every cycle while no stalled result holds the
//  pipeline; the move-state loop (error, integral, three multiplies, sum, clamp) is a single combinational pass.
//  Reset is synchronous, active low; it loads register defaults and idles the
//  move. No clearing pass. A stalled result holds the pipeline; the input
//  stalls only when the input register is full and cannot move on.
// ----------------------------------------------------------------------------
module pid_with_windowed_integral_top
    import pidwi_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input transactions
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic signed [31:0] i_target,
    input  logic signed [31:0] i_reading,
    // result transactions
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [7:0]  o_drive,
    output logic               o_done_res,
    output logic               o_timed_out,
    output logic signed [31:0] o_error_value,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_cfg                             r_cfg;
    t_move_state                      r_state;
    t_move_state                      n_state;
    logic signed [INTEGRAL_WIDTH-1:0] r_integral;
    logic signed [INTEGRAL_WIDTH-1:0] n_integral;
    t_result                          n_result;
    t_result                          r_result;

    // input register
    logic               r_s1_valid;
    logic               r_s1_command;
    logic signed [31:0] r_s1_target;
    logic signed [31:0] r_s1_reading;

    logic r_out_valid;
    logic out_load;   // result register can take a new transaction
    logic s1_move;    // input register hands its transaction to the datapath
    logic in_take;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_load;
    assign o_in_stall = r_s1_valid && !out_load;
    assign in_take    = i_in_valid && !o_in_stall;

    // Config writes are always taken; the user must send them only while idle, the block itself does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p          <= RST_GAIN_P;
            r_cfg.gain_i          <= RST_GAIN_I;
            r_cfg.gain_d          <= RST_GAIN_D;
            r_cfg.integral_window <= RST_INTEGRAL_WINDOW;
            r_cfg.settle_error    <= RST_SETTLE_ERROR;
            r_cfg.settle_rate     <= RST_SETTLE_RATE;
            r_cfg.timeout_samples <= RST_TIMEOUT_SAMPLES;
            r_cfg.output_limit    <= RST_OUTPUT_LIMIT;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P:          r_cfg.gain_p          <= i_cfg_data[15:0];
                CFG_GAIN_I:          r_cfg.gain_i          <= i_cfg_data[15:0];
                CFG_GAIN_D:          r_cfg.gain_d          <= i_cfg_data[15:0];
                CFG_INTEGRAL_WINDOW: r_cfg.integral_window <= i_cfg_data[30:0];
                CFG_SETTLE_ERROR:    r_cfg.settle_error    <= i_cfg_data[30:0];
                CFG_SETTLE_RATE:     r_cfg.settle_rate     <= i_cfg_data[30:0];
                CFG_TIMEOUT_SAMPLES: r_cfg.timeout_samples <= i_cfg_data[15:0];
                CFG_OUTPUT_LIMIT:    r_cfg.output_limit    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Input register: payload has no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_command <= i_command;
            r_s1_target  <= i_target;
            r_s1_reading <= i_reading;
        end
    end

    pidwi_core #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_core (
        .i_cfg      (r_cfg),
        .i_state    (r_state),
        .i_integral (r_integral),
        .i_command  (r_s1_command),
        .i_target   (r_s1_target),
        .i_reading  (r_s1_reading),
        .o_state    (n_state),
        .o_integral (n_integral),
        .o_result   (n_result)
    );

    // Move state advances in the same cycle its result is registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= '0;
            r_integral <= '0;
        end else if (s1_move) begin
            r_state    <= n_state;
            r_integral <= n_integral;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_result.drive;
    assign o_done_res    = r_result.done_res;
    assign o_timed_out   = r_result.timed_out;
    assign o_error_value = r_result.error_value;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A finished move never drives the motor
    a_done_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_drive == 8'sd0)
        else $error("done result with nonzero drive");

    // Timeout is only reported on a finished move
    a_timeout_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_timed_out |-> o_done_res)
        else $error("timeout without done");

    // The pending result and the move state agree on whether a move is armed
    a_state_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state.active == !o_done_res)
        else $error("move state disagrees with pending result");

    // Drive stays within the configured clamp
    a_drive_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive <= signed'({1'b0, r_cfg.output_limit})) &&
                        (o_drive >= -signed'({1'b0, r_cfg.output_limit})))
        else $error("drive exceeds output limit");

endmodule
